FILE: rtl/lgs_pkg.sv
// Shared types and constants for the life grid generation step block.
package lgs_pkg;
  localparam int GridRows = 128;
  localparam int GridColumns = 128;
  localparam int RowW = $clog2(GridRows);
  localparam int ColW = $clog2(GridColumns);

  typedef logic [GridColumns-1:0] row_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Neighbour row and edge control handed along the chain of column cells.
  typedef struct packed {
    logic wrap;
    logic above_en;
    logic below_en;
  } edge_ctl_t;
endpackage

FILE: rtl/lgs_cell.sv
// One column cell: applies the B3/S23 rule to its own column of a row.
module lgs_cell (
  input  logic [2:0] left_i,   // above, current, below of the column to the left
  input  logic [2:0] mid_i,
  input  logic [2:0] right_i,
  output logic       next_o
);
  logic [3:0] live;
  always_comb begin
    live = 4'(left_i[0]) + 4'(left_i[1]) + 4'(left_i[2])
         + 4'(right_i[0]) + 4'(right_i[1]) + 4'(right_i[2])
         + 4'(mid_i[0]) + 4'(mid_i[2]);
    if (mid_i[1]) next_o = (live == 4'd2) || (live == 4'd3);
    else next_o = (live == 4'd3);
  end
endmodule

FILE: rtl/lgs_row_chain.sv
// Row of column cells computing the next generation of one grid row.
module lgs_row_chain (
  input  lgs_pkg::row_t      above_i,
  input  lgs_pkg::row_t      cur_i,
  input  lgs_pkg::row_t      below_i,
  input  lgs_pkg::edge_ctl_t ctl_i,
  output lgs_pkg::row_t      next_o
);
  import lgs_pkg::*;
  logic [GridColumns+1:0] a_x, c_x, b_x;
  row_t a_m, b_m;
  assign a_m = ctl_i.above_en ? above_i : '0;
  assign b_m = ctl_i.below_en ? below_i : '0;
  // pad the row with edge columns, wrapped or dead
  assign a_x = {ctl_i.wrap & a_m[0], a_m, ctl_i.wrap & a_m[GridColumns-1]};
  assign c_x = {ctl_i.wrap & cur_i[0], cur_i, ctl_i.wrap & cur_i[GridColumns-1]};
  assign b_x = {ctl_i.wrap & b_m[0], b_m, ctl_i.wrap & b_m[GridColumns-1]};
  for (genvar c = 0; c < GridColumns; c++) begin : g_col
    lgs_cell u_cell (
      .left_i ({b_x[c],   c_x[c],   a_x[c]}),
      .mid_i  ({b_x[c+1], c_x[c+1], a_x[c+1]}),
      .right_i({b_x[c+2], c_x[c+2], a_x[c+2]}),
      .next_o (next_o[c])
    );
  end
endmodule

FILE: rtl/life_grid_generation_step.sv
// Top level: grid memory, step sequencer and stream ports.
// Write/read items: the cell's row is read, then the cell is written or sampled for the result. Step items:
// every grid row is updated in turn, then a cell is toggled when toggle_enable is set; each grid row takes
// two row reads and one row write, the row update done by a chain of column cells. One item in flight;
// the next item is taken the cycle after the result leaves.
// Reset (rst_n low, synchronous) runs a clearing pass over every row of the grid memory before the first
// item is taken; wrap_edges resets to 1.
module life_grid_generation_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // wrap_edges
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tuser,      // action[1:0]
  input  logic [15:0] in_tdata,      // cell_row[6:0], cell_column[13:7], write_value[14], toggle_enable[15]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tuser,     // done_action[1:0]
  output logic [7:0]  out_tdata      // cell_value[0]
);
  import lgs_pkg::*;
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_RDW, S_CELL, S_T0, S_T1, S_LOADA,
    S_LOADB, S_CALC, S_TGLR, S_TGLW, S_OUT
  } state_t;

  state_t     st_r;
  row_t       mem [GridRows];
  row_t       rdata_r;
  logic       rd_en, wr_en;
  logic [RowW-1:0] rd_addr, wr_addr;
  row_t       wdata;
  logic       wrap_r;
  logic [1:0] act_r;
  logic [RowW-1:0] row_r, r_r;
  logic [ColW-1:0] col_r;
  logic       wv_r, tg_r, val_r;
  row_t       top_r, above_r, cur_r, nxt_row;
  logic       out_v_r;
  edge_ctl_t  ctl;
  logic [RowW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wdata;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  assign ctl.wrap = wrap_r;
  assign ctl.above_en = wrap_r || (r_r != '0);
  assign ctl.below_en = wrap_r || (r_r != RowW'(GridRows-1));
  // row 0 above is the stored last row; last row below is the saved first row
  lgs_row_chain u_chain (
    .above_i(above_r), .cur_i(cur_r),
    .below_i((r_r == RowW'(GridRows-1)) ? top_r : rdata_r),
    .ctl_i(ctl), .next_o(nxt_row)
  );

  always_comb begin
    rd_en = 1'b0; wr_en = 1'b0; rd_addr = r_r; wr_addr = r_r; wdata = nxt_row;
    case (st_r)
      S_CLEAR: begin wr_en = 1'b1; wr_addr = clr_r; wdata = '0; end
      S_RD:    begin rd_en = 1'b1; rd_addr = row_r; end
      S_CELL:  begin
        wr_en = (act_r == ACT_WRITE); wr_addr = row_r;
        wdata = rdata_r; wdata[col_r] = wv_r;
      end
      S_T0:    begin rd_en = 1'b1; rd_addr = RowW'(GridRows-1); end
      S_T1:    begin rd_en = 1'b1; rd_addr = '0; end
      S_LOADA: begin rd_en = 1'b1; rd_addr = r_r; end
      S_LOADB: begin rd_en = 1'b1; rd_addr = r_r + RowW'(1); end
      S_CALC:  wr_en = 1'b1;
      S_TGLR:  begin rd_en = 1'b1; rd_addr = row_r; end
      S_TGLW:  begin
        wr_en = 1'b1; wr_addr = row_r;
        wdata = rdata_r; wdata[col_r] = ~rdata_r[col_r];
      end
      default: ;
    endcase
  end

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tuser = {6'd0, act_r};
  assign out_tdata = {7'd0, val_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; clr_r <= '0; wrap_r <= 1'b1; out_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) wrap_r <= cfg_wr_data;
      case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == RowW'(GridRows-1)) st_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          act_r <= in_tuser[1:0]; row_r <= in_tdata[6:0]; col_r <= in_tdata[13:7];
          wv_r <= in_tdata[14]; tg_r <= in_tdata[15]; val_r <= 1'b0;
          case (action_t'(in_tuser[1:0]))
            ACT_STEP:  st_r <= S_T0;
            ACT_NONE:  st_r <= S_IDLE;
            default:   st_r <= S_RD;
          endcase
        end
        S_RD:   st_r <= S_RDW;
        S_RDW:  st_r <= (act_r == ACT_STEP) ? S_TGLW : S_CELL;
        S_CELL: begin
          if (act_r == ACT_READ) val_r <= rdata_r[col_r];
          out_v_r <= 1'b1; st_r <= S_OUT;
        end
        S_T0: st_r <= S_T1;
        S_T1: begin above_r <= rdata_r; r_r <= '0; st_r <= S_LOADA; end
        S_LOADA: begin
          if (r_r == '0) top_r <= rdata_r;
          st_r <= S_LOADB;
        end
        S_LOADB: begin cur_r <= rdata_r; st_r <= S_CALC; end
        S_CALC: begin
          // hold the original current row as the next row's above
          above_r <= cur_r;
          if (r_r == RowW'(GridRows-1)) begin
            st_r <= tg_r ? S_TGLR : S_OUT;
            out_v_r <= !tg_r;
          end else begin
            r_r <= r_r + RowW'(1); st_r <= S_LOADA;
          end
        end
        S_TGLR: st_r <= S_RDW;
        S_TGLW: begin out_v_r <= 1'b1; st_r <= S_OUT; end
        S_OUT: if (out_tready) begin out_v_r <= 1'b0; st_r <= S_IDLE; end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("item accepted with result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tuser))
    else $error("result dropped");
  a_step_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CALC) |-> (act_r == ACT_STEP)) else $error("row update outside step");
endmodule
